// ===== sv/sobel_pkg.sv =====
// Package: shared types and constants for the Sobel edge magnitude block.
package sobel_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = 2'd2;

    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd4096;

    localparam logic [7:0] MAG_SAT = 8'd255;

    typedef struct packed {
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
    } pixel_t;

    typedef struct packed {
        logic [11:0] out_row;
        logic [9:0]  out_col;
        logic [7:0]  mag0;
        logic [7:0]  mag1;
        logic [7:0]  mag2;
        logic        last_of_run;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_SQRT,
        ST_EMIT_INT,
        ST_EMIT_BORDER
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic calc;
        logic sqrt_step;
        logic emit_int;
        logic emit_border;
    } sobel_cmd_t;

    typedef struct packed {
        logic has_int;
        logic has_border;
        logic sqrt_done;
        logic out_free;
    } sobel_sts_t;

endpackage

// ===== sv/sobel_edge_magnitude.sv =====
// Top level: Sobel 3x3 gradient magnitude over a raster pixel stream.
// Usage: pixels enter on in_valid/in_stall in raster order, one transaction
// per pixel. Each pixel yields zero, one or two results on out_valid/
// out_stall: first the interior pixel one row up and one column left (when
// row and column are both at least 2), then the pixel itself if it lies on
// the frame border. Results are tagged with row and column.
// Sequencing: a pixel is accepted in the idle cycle; one with an interior result
// then runs the 8-step bit-serial integer square root, one root per channel with
// a shared step counter, before its results are emitted. One pixel is in flight
// at a time.
// The output register lets the next pixel be taken while a result waits.
// A stalled output holds its result and the controller waits to emit more.
// Reset clears counters, window and control; line stores keep no reset.
// Configuration writes (cfg_valid/cfg_ready) restart the frame at row 0,
// column 0 and should happen only when the block is idle.
module sobel_edge_magnitude
#(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 4096
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  sobel_pkg::pixel_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output sobel_pkg::result_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [10:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic        color_mode_reg;
    logic        cfg_write;
    sobel_pkg::sobel_cmd_t cmd;
    sobel_pkg::sobel_sts_t sts;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready
                    && (cfg_index == sobel_pkg::REG_FRAME_WIDTH
                     || cfg_index == sobel_pkg::REG_FRAME_HEIGHT
                     || cfg_index == sobel_pkg::REG_COLOR_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= sobel_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= sobel_pkg::FRAME_HEIGHT_RESET;
            color_mode_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sobel_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[10:0];
                sobel_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[12:0];
                sobel_pkg::REG_COLOR_MODE:   color_mode_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    sobel_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sobel_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_data      (in_data),
        .cfg_write    (cfg_write),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .color_mode   (color_mode_reg),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_int && cmd.emit_border))
        else $error("two emit commands at once");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !(cmd.emit_int || cmd.emit_border))
        else $error("result overwritten while stalled");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second pixel accepted while busy");

endmodule

// ===== sv/sobel_ctrl.sv =====
// Controller: sequences one pixel through line store read, gradient, root and emission.
module sobel_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sobel_pkg::sobel_sts_t sts,
    output sobel_pkg::sobel_cmd_t cmd
);

    sobel_pkg::state_t state_reg;
    sobel_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sobel_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sobel_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sobel_pkg::ST_READ;
                end
            end
            sobel_pkg::ST_READ:
            begin
                if (sts.has_int)
                begin
                    state_next = sobel_pkg::ST_CALC;
                end
                else if (sts.has_border)
                begin
                    state_next = sobel_pkg::ST_EMIT_BORDER;
                end
                else
                begin
                    state_next = sobel_pkg::ST_IDLE;
                end
            end
            sobel_pkg::ST_CALC:
            begin
                state_next = sobel_pkg::ST_SQRT;
            end
            sobel_pkg::ST_SQRT:
            begin
                if (sts.sqrt_done)
                begin
                    state_next = sobel_pkg::ST_EMIT_INT;
                end
            end
            sobel_pkg::ST_EMIT_INT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.has_border ? sobel_pkg::ST_EMIT_BORDER
                                                : sobel_pkg::ST_IDLE;
                end
            end
            sobel_pkg::ST_EMIT_BORDER:
            begin
                if (sts.out_free)
                begin
                    state_next = sobel_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sobel_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            sobel_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            sobel_pkg::ST_READ:
            begin
                cmd.shift = 1'b1;
            end
            sobel_pkg::ST_CALC:
            begin
                cmd.calc = 1'b1;
            end
            sobel_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
            end
            sobel_pkg::ST_EMIT_INT:
            begin
                cmd.emit_int = sts.out_free;
            end
            sobel_pkg::ST_EMIT_BORDER:
            begin
                cmd.emit_border = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/sobel_dp.sv =====
// Datapath: line stores, window, counters, gradients, per-channel integer roots and output register.
module sobel_dp
#(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sobel_pkg::pixel_t     in_data,
    input  logic                  cfg_write,
    input  logic [10:0]           frame_width,
    input  logic [12:0]           frame_height,
    input  logic                  color_mode,
    input  sobel_pkg::sobel_cmd_t cmd,
    output sobel_pkg::sobel_sts_t sts,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sobel_pkg::result_t    out_data
);

    localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned WCW   = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HCW   = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned SQ_STEPS = 8;

    logic [23:0] upper_mem [MAX_WIDTH];
    logic [23:0] middle_mem [MAX_WIDTH];

    logic [23:0] win_reg [3][3];
    logic [23:0] up_rd_reg;
    logic [23:0] mid_rd_reg;
    logic [23:0] px_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] cur_col_reg;
    logic [ROW_W-1:0] cur_row_reg;
    logic has_int_reg;
    logic has_border_reg;
    logic color_reg;

    logic [16:0] sq_val_reg [3];
    logic [16:0] sq_rem_reg [3];
    logic [7:0]  sq_res_reg [3];
    logic [3:0]  sq_cnt_reg;
    logic [7:0]  mag_reg [3];

    logic out_valid_reg;
    sobel_pkg::result_t out_data_reg;

    logic [WCW-1:0] eff_w;
    logic [HCW-1:0] eff_h;
    logic [COL_W-1:0] cur_c;
    logic [ROW_W-1:0] cur_r;
    logic [23:0] px_in;

    always_comb
    begin
        if ({2'b0, frame_width} < 13'd3)
        begin
            eff_w = WCW'(3);
        end
        else if (32'(frame_width) > MAX_WIDTH)
        begin
            eff_w = WCW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WCW'(frame_width);
        end
        if (frame_height < 13'd3)
        begin
            eff_h = HCW'(3);
        end
        else if (32'(frame_height) > MAX_HEIGHT)
        begin
            eff_h = HCW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HCW'(frame_height);
        end
        cur_c = (32'(col_reg) >= 32'(eff_w)) ? COL_W'(eff_w - 1'b1) : col_reg;
        cur_r = (32'(row_reg) >= 32'(eff_h)) ? ROW_W'(eff_h - 1'b1) : row_reg;
        px_in = color_mode ? {in_data.chan2, in_data.chan1, in_data.chan0}
                           : {16'd0, in_data.chan0};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            up_rd_reg        <= upper_mem[cur_c];
            mid_rd_reg       <= middle_mem[cur_c];
            upper_mem[cur_c] <= middle_mem[cur_c];
            middle_mem[cur_c] <= px_in;
            px_reg           <= px_in;
            cur_col_reg      <= cur_c;
            cur_row_reg      <= cur_r;
            color_reg        <= color_mode;
            has_int_reg      <= (cur_r >= ROW_W'(2)) && (cur_c >= COL_W'(2));
            has_border_reg   <= (cur_r == '0) || (32'(cur_r) == 32'(eff_h) - 1)
                             || (cur_c == '0) || (32'(cur_c) == 32'(eff_w) - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_write)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.load)
            begin
                if (32'(cur_c) + 1 >= 32'(eff_w))
                begin
                    col_reg <= '0;
                    row_reg <= (32'(cur_r) + 1 >= 32'(eff_h)) ? '0 : cur_r + 1'b1;
                end
                else
                begin
                    col_reg <= cur_c + 1'b1;
                    row_reg <= cur_r;
                end
            end
            if (cmd.shift)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= up_rd_reg;
                win_reg[1][2] <= mid_rd_reg;
                win_reg[2][2] <= px_reg;
            end
        end
    end

    logic signed [10:0] gx [3];
    logic signed [10:0] gy [3];
    logic [9:0] ax [3];
    logic [9:0] ay [3];
    logic [20:0] ssum [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            gx[k] = 11'(win_reg[0][2][8*k +: 8]) + (11'(win_reg[1][2][8*k +: 8]) << 1)
                  + 11'(win_reg[2][2][8*k +: 8]) - 11'(win_reg[0][0][8*k +: 8])
                  - (11'(win_reg[1][0][8*k +: 8]) << 1) - 11'(win_reg[2][0][8*k +: 8]);
            gy[k] = 11'(win_reg[0][0][8*k +: 8]) + (11'(win_reg[0][1][8*k +: 8]) << 1)
                  + 11'(win_reg[0][2][8*k +: 8]) - 11'(win_reg[2][0][8*k +: 8])
                  - (11'(win_reg[2][1][8*k +: 8]) << 1) - 11'(win_reg[2][2][8*k +: 8]);
            ax[k] = gx[k][10] ? 10'(-gx[k]) : 10'(gx[k]);
            ay[k] = gy[k][10] ? 10'(-gy[k]) : 10'(gy[k]);
            ssum[k] = 21'(ax[k] * ax[k]) + 21'(ay[k] * ay[k]);
        end
    end

    logic [16:0] trial [3];
    logic [3:0]  sq_shift;

    always_comb
    begin
        sq_shift = 4'(2 * (SQ_STEPS - 1)) - {sq_cnt_reg[2:0], 1'b0};
        for (int k = 0; k < 3; k++)
        begin
            trial[k] = {sq_rem_reg[k][14:0], 2'(sq_val_reg[k] >> sq_shift)}
                     - {7'd0, sq_res_reg[k], 2'b01};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_cnt_reg <= '0;
        end
        else if (cmd.calc)
        begin
            sq_cnt_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_val_reg[k] <= (ssum[k] >= 21'd65536) ? 17'h1FFFF : 17'(ssum[k]);
                sq_rem_reg[k] <= '0;
                sq_res_reg[k] <= '0;
            end
        end
        else if (cmd.sqrt_step)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (sq_val_reg[k][16])
                begin
                    mag_reg[k] <= sobel_pkg::MAG_SAT;
                end
                else if (!trial[k][16])
                begin
                    sq_rem_reg[k] <= trial[k];
                    sq_res_reg[k] <= {sq_res_reg[k][6:0], 1'b1};
                    mag_reg[k]    <= {sq_res_reg[k][6:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[k] <= {sq_rem_reg[k][14:0], 2'(sq_val_reg[k] >> sq_shift)};
                    sq_res_reg[k] <= {sq_res_reg[k][6:0], 1'b0};
                    mag_reg[k]    <= {sq_res_reg[k][6:0], 1'b0};
                end
            end
        end
    end

    logic out_take;
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_int || cmd.emit_border)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_int)
        begin
            out_data_reg.out_row     <= 12'(cur_row_reg - 1'b1);
            out_data_reg.out_col     <= 10'(cur_col_reg - 1'b1);
            out_data_reg.mag0        <= mag_reg[0];
            out_data_reg.mag1        <= color_reg ? mag_reg[1] : 8'd0;
            out_data_reg.mag2        <= color_reg ? mag_reg[2] : 8'd0;
            out_data_reg.last_of_run <= !has_border_reg;
        end
        else if (cmd.emit_border)
        begin
            out_data_reg.out_row     <= 12'(cur_row_reg);
            out_data_reg.out_col     <= 10'(cur_col_reg);
            out_data_reg.mag0        <= px_reg[7:0];
            out_data_reg.mag1        <= px_reg[15:8];
            out_data_reg.mag2        <= px_reg[23:16];
            out_data_reg.last_of_run <= 1'b1;
        end
    end

    assign sts.has_int    = has_int_reg;
    assign sts.has_border = has_border_reg;
    assign sts.sqrt_done  = (sq_cnt_reg == 4'(SQ_STEPS - 1));
    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;

endmodule
